>>> rtl/mbrf_pkg.sv
// Shared types, constants and byte/CRC helpers for the Modbus RTU request framer.
package mbrf_pkg;

  localparam int unsigned IDX_W = 3;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] COUNT_SHORT  = 16'hFFFF;
  localparam logic [15:0] COUNT_FIXED  = 16'hF170;
  localparam logic [7:0]  FIXED_BYTE_0 = 8'h37;
  localparam logic [7:0]  FIXED_BYTE_1 = 8'h21;

  localparam logic [IDX_W-1:0] BODY_NORMAL = 3'd6;
  localparam logic [IDX_W-1:0] BODY_SHORT  = 3'd2;
  localparam logic [IDX_W-1:0] BODY_FIXED  = 3'd4;

  typedef enum logic [1:0] {
    FRAME_NORMAL,
    FRAME_SHORT,
    FRAME_FIXED
  } frame_kind_t;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_count;
  } request_t;

  // Fold one byte into a running CRC-16/MODBUS value.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Classify a request by its register count.
  function automatic frame_kind_t frame_kind(input logic [15:0] count);
    frame_kind_t k;
    if (count == COUNT_SHORT) begin
      k = FRAME_SHORT;
    end else if (count == COUNT_FIXED) begin
      k = FRAME_FIXED;
    end else begin
      k = FRAME_NORMAL;
    end
    return k;
  endfunction

  // Number of bytes ahead of the CRC.
  function automatic logic [IDX_W-1:0] body_len(input frame_kind_t kind);
    logic [IDX_W-1:0] n;
    case (kind)
      FRAME_SHORT: n = BODY_SHORT;
      FRAME_FIXED: n = BODY_FIXED;
      default:     n = BODY_NORMAL;
    endcase
    return n;
  endfunction

  // Pick the body byte at a given position of the frame.
  function automatic logic [7:0] body_byte(input request_t r, input frame_kind_t kind,
                                           input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = r.slave_address;
      3'd1:    b = r.function_code;
      3'd2:    b = (kind == FRAME_FIXED) ? FIXED_BYTE_0 : r.register_address[15:8];
      3'd3:    b = (kind == FRAME_FIXED) ? FIXED_BYTE_1 : r.register_address[7:0];
      3'd4:    b = r.register_count[15:8];
      3'd5:    b = r.register_count[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/mbrf_req_if.sv
// Request channel: one framing request with valid/ready handshake.
interface mbrf_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] register_address;
  logic [15:0] register_count;

  modport source (output valid, output slave_address, output function_code,
                  output register_address, output register_count, input ready);
  modport sink   (input valid, input slave_address, input function_code,
                  input register_address, input register_count, output ready);
endinterface

>>> rtl/mbrf_byte_if.sv
// Byte channel: one frame byte with a last-byte flag and valid/ready handshake.
interface mbrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

>>> rtl/mbrf_serializer.sv
// Frame serializer: walks one request byte by byte, folding the CRC as bytes leave.
module mbrf_serializer
  import mbrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pend_valid,
  input  request_t    pend,
  output logic        pend_take,
  mbrf_byte_if.source rsp
);

  logic             act_valid;
  request_t         act;
  frame_kind_t      kind;
  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;

  logic             out_free;
  logic             step;
  logic [IDX_W-1:0] blen;
  logic             in_body;
  logic             is_last;
  logic [7:0]       cur_body;
  logic [7:0]       byte_next;
  logic             act_free;

  // Select the byte at the current position
  always_comb begin
    out_free  = !out_valid || rsp.ready;
    step      = act_valid && out_free;
    blen      = body_len(kind);
    in_body   = idx < blen;
    is_last   = idx == (blen + 3'd1);
    cur_body  = body_byte(act, kind, idx);
    if (in_body) begin
      byte_next = cur_body;
    end else if (idx == blen) begin
      byte_next = crc[7:0];
    end else begin
      byte_next = crc[15:8];
    end
    act_free  = !act_valid || (step && is_last);
    pend_take = act_free && pend_valid;
  end

  // Advance the active frame and load the next request when it ends
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else if (pend_take) begin
      act_valid <= 1'b1;
    end else if (step && is_last) begin
      act_valid <= 1'b0;
    end

    if (pend_take) begin
      act  <= pend;
      kind <= frame_kind(pend.register_count);
      idx  <= '0;
      crc  <= CRC_INIT;
    end else if (step) begin
      idx <= idx + 3'd1;
      if (in_body) begin
        crc <= crc_feed(crc, cur_body);
      end
    end
  end

  // Hold the output byte until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end

    if (step) begin
      out_byte <= byte_next;
      out_last <= is_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.frame_byte = out_byte;
  assign rsp.last_byte  = out_last;

endmodule

>>> rtl/modbus_rtu_request_framer.sv
// Top level of the Modbus RTU request framer: request buffer and byte serializer.
//
//   channel | dir | handshake       | payload
//   req     | in  | valid / ready   | slave_address, function_code,
//           |     |                 | register_address, register_count
//   rsp     | out | valid / ready   | frame_byte, last_byte
//
// One frame byte leaves per cycle while rsp is not stalled: 8 bytes per normal
// request, 4 for the short frame, 6 for the fixed-payload frame; the byte serializer sets this.
// The CRC is folded one byte per cycle as each body byte goes out, unless rsp stalls.
// A one-deep request buffer takes the next request while a frame is still
// going out; the output byte register holds under a stall on rsp.
// Reset (rst, synchronous) drops any buffered request and pending byte.
module modbus_rtu_request_framer
  import mbrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mbrf_req_if.sink    req,
  mbrf_byte_if.source rsp
);

  logic     pend_valid;
  request_t pend;
  logic     pend_take;

  assign req.ready = !pend_valid;

  // Buffer one request ahead of the serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      pend_valid <= 1'b1;
    end else if (pend_take) begin
      pend_valid <= 1'b0;
    end

    if (req.valid && req.ready) begin
      pend.slave_address    <= req.slave_address;
      pend.function_code    <= req.function_code;
      pend.register_address <= req.register_address;
      pend.register_count   <= req.register_count;
    end
  end

  mbrf_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .pend_valid (pend_valid),
    .pend       (pend),
    .pend_take  (pend_take),
    .rsp        (rsp)
  );

endmodule

>>> verif/tb.sv
// Testbench for modbus_rtu_request_framer: random and directed requests, frame byte checks.
module tb;
  import mbrf_pkg::*;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 102;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst;

  mbrf_req_if  req_ch();
  mbrf_byte_if byte_ch();

  modbus_rtu_request_framer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (byte_ch)
  );

  request_t    pending_requests[$];
  frame_beat_t frame_bytes[$];
  int          errors;
  int          quiet_cycles;
  bit          req_fire;
  bit          byte_fire;

  // Fold one byte into a CRC-16/MODBUS value, one bit at a time.
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Build the frame for one request and queue its bytes.
  function automatic void frame_request(input request_t r);
    logic [7:0]  body[$];
    logic [15:0] crc;
    body.push_back(r.slave_address);
    body.push_back(r.function_code);
    if (r.register_count == COUNT_FIXED) begin
      body.push_back(FIXED_BYTE_0);
      body.push_back(FIXED_BYTE_1);
    end else if (r.register_count != COUNT_SHORT) begin
      body.push_back(r.register_address[15:8]);
      body.push_back(r.register_address[7:0]);
      body.push_back(r.register_count[15:8]);
      body.push_back(r.register_count[7:0]);
    end
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_fold(crc, body[i]);
      frame_bytes.push_back(frame_beat_t'{body[i], 1'b0});
    end
    frame_bytes.push_back(frame_beat_t'{crc[7:0], 1'b0});
    frame_bytes.push_back(frame_beat_t'{crc[15:8], 1'b1});
  endfunction

  task automatic add_request(input logic [7:0] sa, input logic [7:0] fc,
                             input logic [15:0] ra, input logic [15:0] rc);
    request_t r;
    r.slave_address    = sa;
    r.function_code    = fc;
    r.register_address = ra;
    r.register_count   = rc;
    pending_requests.push_back(r);
  endtask

  // Run the clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Send requests in bursts with random gaps.
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        r = pending_requests.pop_front();
        req_ch.slave_address    <= r.slave_address;
        req_ch.function_code    <= r.function_code;
        req_ch.register_address <= r.register_address;
        req_ch.register_count   <= r.register_count;
        req_ch.valid            <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the byte sink on a pattern that changes mode now and then.
  int stall_mode;
  int mode_timer;
  int stall_left;
  int stall_phase;

  always @(negedge clk) begin
    if (mode_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_timer = $urandom_range(30, 90);
    end else begin
      mode_timer--;
    end
    stall_phase++;
    if (stall_left > 0) begin
      stall_left--;
      byte_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: byte_ch.ready <= 1'b1;
        1: byte_ch.ready <= 1'($urandom_range(0, 1));
        2: byte_ch.ready <= (stall_phase % 4 != 3);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(5, 20);
            byte_ch.ready <= 1'b0;
          end else begin
            byte_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Predict accepted requests, check frame bytes, and watch for a hang.
  always @(posedge clk) begin
    frame_beat_t want;
    request_t    r;
    req_fire  = !rst && req_ch.valid && req_ch.ready;
    byte_fire = !rst && byte_ch.valid && byte_ch.ready;
    if (req_fire) begin
      r.slave_address    = req_ch.slave_address;
      r.function_code    = req_ch.function_code;
      r.register_address = req_ch.register_address;
      r.register_count   = req_ch.register_count;
      frame_request(r);
    end
    if (byte_fire) begin
      if (frame_bytes.size() == 0) begin
        $error("frame_byte with no request pending: got %02h", byte_ch.frame_byte);
        errors++;
      end else begin
        want = frame_bytes.pop_front();
        if (byte_ch.frame_byte !== want.frame_byte) begin
          $error("frame_byte mismatch: expected %02h, got %02h",
                 want.frame_byte, byte_ch.frame_byte);
          errors++;
        end
        if (byte_ch.last_byte !== want.last_byte) begin
          $error("last_byte mismatch: expected %0b, got %0b",
                 want.last_byte, byte_ch.last_byte);
          errors++;
        end
      end
    end
    if (rst || req_fire || byte_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Load the request list, reset, and wait for every frame to drain.
  initial begin
    logic [15:0] rc;
    errors       = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    gap_left     = 0;
    stall_mode   = 0;
    mode_timer   = 40;
    stall_left   = 0;
    stall_phase  = 0;
    req_fire     = 1'b0;
    byte_fire    = 1'b0;
    rst          = 1'b1;
    req_ch.valid            = 1'b0;
    req_ch.slave_address    = '0;
    req_ch.function_code    = '0;
    req_ch.register_address = '0;
    req_ch.register_count   = '0;
    byte_ch.ready           = 1'b0;

    // Directed: field extremes, both special counts and their neighbors.
    add_request(8'h01, 8'h03, 16'h0000, 16'h000A);
    add_request(8'h00, 8'h00, 16'h0000, 16'h0000);
    add_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFE);
    add_request(8'hFF, 8'hFF, 16'hFFFF, COUNT_SHORT);
    add_request(8'h00, 8'h00, 16'h0000, COUNT_SHORT);
    add_request(8'h11, 8'h06, 16'h1234, COUNT_SHORT);
    add_request(8'hFF, 8'hFF, 16'hFFFF, COUNT_FIXED);
    add_request(8'h00, 8'h00, 16'h0000, COUNT_FIXED);
    add_request(8'h5A, 8'hA5, 16'hBEEF, COUNT_FIXED);
    add_request(8'h7F, 8'h80, 16'h8000, 16'hF171);
    add_request(8'h80, 8'h7F, 16'h7FFF, 16'hF16F);
    add_request(8'h01, 8'h10, 16'h00FF, 16'h7FFF);
    add_request(8'hF7, 8'h04, 16'hFF00, 16'hFF7F);
    add_request(8'h02, 8'h01, 16'h5555, 16'h7170);
    add_request(8'hAA, 8'h55, 16'hAAAA, 16'h0001);
    add_request(8'h01, 8'h03, 16'hFFFF, 16'hFFFF);
    add_request(8'hC3, 8'h3C, 16'h0F0F, 16'hF0F0);
    add_request(8'h01, 8'h03, 16'h0001, 16'h0001);

    // Random: half arbitrary counts, the rest special and near-special ones.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      case ($urandom_range(0, 9))
        0, 1:    rc = COUNT_SHORT;
        2, 3:    rc = COUNT_FIXED;
        4:       rc = (($urandom_range(0, 1) == 0) ? COUNT_SHORT : COUNT_FIXED)
                      ^ (16'h0001 << $urandom_range(0, 15));
        default: rc = 16'($urandom_range(0, 16'hFFFF));
      endcase
      add_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 16'hFFFF)), rc);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (frame_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
